// ===== rtl/bmp24_pkg.sv =====
// Shared constants and types for the 24-bit bitmap stream decoder.
package bmp24_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 1;
  localparam int COORD_W   = 12;

  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [31:0] HDR_OS2   = 32'd12;
  localparam logic [31:0] HDR_V3    = 32'd40;
  localparam logic [31:0] DEPTH_24  = 32'd24;
  localparam logic [31:0] END_OS2   = 32'd26;
  localparam logic [31:0] END_V3    = 32'd54;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_SIGNATURE,
    ERR_HEADER,
    ERR_DEPTH,
    ERR_COMPRESSED,
    ERR_TOO_LARGE,
    ERR_OFFSET
  } err_code_t;

  typedef enum logic {
    KIND_PIXEL,
    KIND_ERROR
  } result_kind_t;

  typedef struct packed {
    result_kind_t         kind;
    err_code_t            code;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/bmp24_stream_decoder_unit.sv =====
// Byte-serial decoder for uncompressed 24-bit bitmap files, RGB pixel stream out.
//
// Input stream: one file byte per request in s_tdata; s_tuser flags the first
// byte of a new file and restarts parsing on that byte. Output stream: one
// request per pixel (m_tuser kind pixel) or one error request that ends the
// file; m_tlast marks the final pixel of the image.
// Throughput is one byte per cycle while s_tready is high; the header, skip and padding
// bytes are consumed without producing output. A result is registered when the
// byte that completes it is taken (into the skid register if one is waiting).
// The output has a two-deep buffer (result register plus skid register), so
// bytes keep flowing while one result waits; s_tready drops only once both
// hold results, and rises again the cycle after the receiver takes one.
// After an error or the last pixel all bytes are dropped until the next
// start-of-file flag.
// Reset (rst, synchronous) empties the output buffer and puts the parser in
// signature state, as if a new file were starting.
module bmp24_stream_decoder_unit #(
  parameter int MAX_DIM = bmp24_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bmp24_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] file_byte
  input  logic [bmp24_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] file_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] error_code, [10:3] red, [18:11] green, [26:19] blue,
  // [38:27] pixel_column, [50:39] pixel_row, [55:51] zero
  output logic [bmp24_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [bmp24_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] result_kind
  output logic                              m_tlast    // last_pixel
);
  import bmp24_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 2);

  typedef enum logic [2:0] {
    PH_SIGNATURE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

  phase_t            phase, phase_next, cur_phase;
  logic [31:0]       byte_position, byte_position_next, cur_pos;
  logic [31:0]       field_shift, field_shift_next;
  logic [31:0]       data_offset, data_offset_next;
  logic              kind_v3, kind_v3_next;
  logic [DIM_W-1:0]  image_width, image_width_next;
  logic [DIM_W-1:0]  image_height, image_height_next;
  logic [DIM_W-1:0]  column_count, column_count_next;
  logic [DIM_W-1:0]  row_count, row_count_next;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [1:0]        byte_in_pixel, byte_in_pixel_next;
  logic [7:0]        saved_blue, saved_blue_next;
  logic [7:0]        saved_green, saved_green_next;
  logic [1:0]        pad_left, pad_left_next;

  logic [7:0]        b;
  logic [1:0]        start_lo, gk;
  logic [31:0]       gathered;
  logic              do_finish, do_err, do_pixel, has_res, is_last;
  err_code_t         err_code;
  result_t           res;

  result_t           out_reg, skid_reg;
  logic              out_valid, skid_valid;
  logic              accept, push, pop;

  function automatic logic [DIM_W-1:0] dimension(input logic [31:0] raw,
                                                 input logic neg);
    logic [DIM_W-1:0] d;
    if (neg) d = '0;
    else if (raw > 32'(MAX_DIM)) d = DIM_W'(MAX_DIM + 1);
    else d = DIM_W'(raw);
    return d;
  endfunction

  assign b         = s_tdata[7:0];
  assign cur_phase = s_tuser[0] ? PH_SIGNATURE : phase;
  assign cur_pos   = s_tuser[0] ? 32'd0 : byte_position;

  // little-endian field assembly; fields start on position ..2 or ..0 mod 4
  always_comb begin
    start_lo = 2'd2;
    if ((!kind_v3 && cur_pos >= 32'd20 && cur_pos <= 32'd25) ||
        (kind_v3 && cur_pos >= 32'd28 && cur_pos <= 32'd29)) begin
      start_lo = 2'd0;
    end
    gk = cur_pos[1:0] - start_lo;
    if (gk == 2'd0) gathered = {24'd0, b};
    else gathered = field_shift | ({24'd0, b} << {gk, 3'b000});
  end

  always_comb begin
    phase_next         = cur_phase;
    byte_position_next = cur_pos;
    field_shift_next   = field_shift;
    data_offset_next   = data_offset;
    kind_v3_next       = kind_v3;
    image_width_next   = image_width;
    image_height_next  = image_height;
    column_count_next  = column_count;
    row_count_next     = row_count;
    byte_in_pixel_next = byte_in_pixel;
    saved_blue_next    = saved_blue;
    saved_green_next   = saved_green;
    pad_left_next      = pad_left;
    do_finish          = 1'b0;
    do_err             = 1'b0;
    do_pixel           = 1'b0;
    has_res            = 1'b0;
    is_last            = 1'b0;
    err_code           = ERR_NONE;
    res                = '0;
    col_inc            = column_count + DIM_W'(1);
    row_inc            = row_count + DIM_W'(1);

    case (cur_phase)
      PH_SIGNATURE: begin
        if (cur_pos == 32'd0) begin
          field_shift_next   = {24'd0, b};
          byte_position_next = 32'd1;
        end else begin
          byte_position_next = 32'd2;
          if (field_shift[7:0] != SIG_B || field_shift[31:8] != '0 || b != SIG_M) begin
            do_err   = 1'b1;
            err_code = ERR_SIGNATURE;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        byte_position_next = cur_pos + 32'd1;
        if (cur_pos >= 32'd10 && cur_pos <= 32'd13) begin
          field_shift_next = gathered;
          if (cur_pos == 32'd13) data_offset_next = gathered;
        end else if (cur_pos >= 32'd14 && cur_pos <= 32'd17) begin
          field_shift_next = gathered;
          if (cur_pos == 32'd17) begin
            kind_v3_next = (gathered == HDR_V3);
            if (gathered != HDR_OS2 && gathered != HDR_V3) begin
              do_err   = 1'b1;
              err_code = ERR_HEADER;
            end
          end
        end else if (cur_pos >= 32'd18 && !kind_v3) begin
          if (cur_pos <= 32'd19) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd19) image_width_next = dimension(gathered, gathered[15]);
          end else if (cur_pos <= 32'd21) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd21) image_height_next = dimension(gathered, gathered[15]);
          end else if (cur_pos >= 32'd24 && cur_pos <= 32'd25) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd25) begin
              if (gathered != DEPTH_24) begin
                do_err   = 1'b1;
                err_code = ERR_DEPTH;
              end else begin
                do_finish = 1'b1;
              end
            end
          end
        end else if (cur_pos >= 32'd18) begin
          if (cur_pos <= 32'd21) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd21) image_width_next = dimension(gathered, gathered[31]);
          end else if (cur_pos <= 32'd25) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd25) image_height_next = dimension(gathered, gathered[31]);
          end else if (cur_pos >= 32'd28 && cur_pos <= 32'd29) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd29 && gathered != DEPTH_24) begin
              do_err   = 1'b1;
              err_code = ERR_DEPTH;
            end
          end else if (cur_pos >= 32'd30 && cur_pos <= 32'd33) begin
            field_shift_next = gathered;
            if (cur_pos == 32'd33) begin
              if (gathered != 32'd0) begin
                do_err   = 1'b1;
                err_code = ERR_COMPRESSED;
              end else begin
                do_finish = 1'b1;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        if (cur_pos < data_offset) begin
          byte_position_next = cur_pos + 32'd1;
        end else begin
          phase_next = PH_PIXEL;
          do_pixel   = 1'b1;
        end
      end
      PH_PIXEL: do_pixel = 1'b1;
      PH_PAD: begin
        pad_left_next = pad_left - 2'd1;
        if (pad_left == 2'd1) phase_next = PH_PIXEL;
      end
      default: ;
    endcase

    if (do_finish) begin
      if (image_width > DIM_W'(MAX_DIM) || image_height > DIM_W'(MAX_DIM)) begin
        do_err   = 1'b1;
        err_code = ERR_TOO_LARGE;
      end else if (data_offset < (kind_v3 ? END_V3 : END_OS2)) begin
        do_err   = 1'b1;
        err_code = ERR_OFFSET;
      end else if (image_width == '0 || image_height == '0) begin
        phase_next = PH_DONE;
      end else begin
        phase_next         = PH_SKIP;
        column_count_next  = '0;
        row_count_next     = '0;
        byte_in_pixel_next = 2'd0;
      end
    end

    if (do_err) begin
      has_res    = 1'b1;
      res.kind   = KIND_ERROR;
      res.code   = err_code;
      phase_next = PH_DONE;
    end

    if (do_pixel) begin
      case (byte_in_pixel)
        2'd0: begin
          saved_blue_next    = b;
          byte_in_pixel_next = 2'd1;
        end
        2'd1: begin
          saved_green_next   = b;
          byte_in_pixel_next = 2'd2;
        end
        default: begin
          byte_in_pixel_next = 2'd0;
          is_last   = (col_inc == image_width) && (row_inc == image_height);
          has_res   = 1'b1;
          res.kind  = KIND_PIXEL;
          res.code  = ERR_NONE;
          res.red   = b;
          res.green = saved_green;
          res.blue  = saved_blue;
          res.col   = COORD_W'(column_count);
          res.row   = COORD_W'(row_count);
          res.last  = is_last;
          if (is_last) begin
            phase_next        = PH_DONE;
            column_count_next = col_inc;
          end else if (col_inc >= image_width) begin
            column_count_next = '0;
            row_count_next    = row_inc;
            pad_left_next     = image_width[1:0];
            if (image_width[1:0] != 2'd0) phase_next = PH_PAD;
          end else begin
            column_count_next = col_inc;
          end
        end
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && has_res;
  assign pop      = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIGNATURE;
      byte_position <= '0;
      byte_in_pixel <= 2'd0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        byte_position <= byte_position_next;
        field_shift   <= field_shift_next;
        data_offset   <= data_offset_next;
        kind_v3       <= kind_v3_next;
        image_width   <= image_width_next;
        image_height  <= image_height_next;
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        byte_in_pixel <= byte_in_pixel_next;
        saved_blue    <= saved_blue_next;
        saved_green   <= saved_green_next;
        pad_left      <= pad_left_next;
      end
      if (skid_valid) begin
        if (pop) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (push && out_valid && !pop) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end else if (push) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_reg.row, out_reg.col, out_reg.blue, out_reg.green,
                     out_reg.red, out_reg.code};
  assign m_tuser  = out_reg.kind;
  assign m_tlast  = out_reg.last;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while result register is empty");

  a_pixel_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == KIND_PIXEL) |-> out_reg.code == ERR_NONE)
    else $error("pixel result carries an error code");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == KIND_ERROR) |-> (out_reg.code != ERR_NONE && !out_reg.last))
    else $error("error result without code or flagged last");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXEL) |-> column_count < image_width)
    else $error("column counter ran past image width");

  a_pad_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> pad_left != 2'd0)
    else $error("padding state with nothing to drop");
`endif

endmodule
